FILE: sv/drp_pkg.sv
`default_nettype none
package drp_pkg;

  localparam logic [1:0] MODE_IMPEDANCE = 2'd0;
  localparam logic [1:0] MODE_REACTANCE = 2'd1;
  localparam logic [1:0] MODE_MHO       = 2'd2;
  localparam logic [1:0] MODE_UNUSED    = 2'd3;

  localparam logic [1:0] REG_CHAR_MODE    = 2'd0;
  localparam logic [1:0] REG_REACH        = 2'd1;
  localparam logic [1:0] REG_TORQUE_ANGLE = 2'd2;
  localparam logic [1:0] REG_UNUSED       = 2'd3;

  localparam logic [15:0] TORQUE_RESET = 16'd13653;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
  } lane_ctl_t;

  typedef struct packed {
    logic load;
  } merge_ctl_t;

endpackage
`default_nettype wire

FILE: sv/drp_lane.sv
`default_nettype none
module drp_lane #(
  parameter int MAG_WIDTH        = 16,
  parameter int ANGLE_WIDTH      = 16,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  wire logic                   clk,
  input  wire drp_pkg::lane_ctl_t     ctl,
  input  wire logic [1:0]             char_mode,
  input  wire logic [15:0]            reach,
  input  wire logic [15:0]            torque_angle,
  input  wire logic [MAG_WIDTH-1:0]   cur,
  input  wire logic [MAG_WIDTH-1:0]   volt,
  input  wire logic [ANGLE_WIDTH-1:0] iang,
  input  wire logic [ANGLE_WIDTH-1:0] vang,
  output logic                        pick
);

  localparam int FB   = ANGLE_WIDTH - 2;
  localparam int IDXW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int RW   = MAG_WIDTH + 16;
  localparam int PW   = MAG_WIDTH + 32;

  typedef logic [15:0] rom_t [SINE_TABLE_DEPTH+1];

  function automatic rom_t build_rom();
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    rom_t        r;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = (64'(k) * 64'd1686629713) / 64'(SINE_TABLE_DEPTH);
      term = x;
      sum  = x;
      for (int n = 1; n <= 7; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      r[k] = 16'((sum + 64'd16384) >> 15);
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // load stage
  logic [MAG_WIDTH-1:0]   cur1;
  logic [MAG_WIDTH-1:0]   volt1;
  logic [ANGLE_WIDTH-1:0] ang1;
  logic [ANGLE_WIDTH-1:0] dphi;
  logic [ANGLE_WIDTH-1:0] ang_sel;

  always_comb begin
    dphi = vang - iang;
    if (char_mode == drp_pkg::MODE_MHO) begin
      ang_sel = ANGLE_WIDTH'(torque_angle) - dphi + (ANGLE_WIDTH'(1) << FB);
    end else begin
      ang_sel = dphi;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cur1  <= (cur == '0) ? MAG_WIDTH'(1) : cur;
      volt1 <= volt;
      ang1  <= ang_sel;
    end
  end

  // table read stage
  logic [FB+IDXW-1:0] fscaled;
  logic [IDXW-1:0]    idx;
  logic [IDXW-1:0]    addr;
  logic [15:0]        rom2;
  logic               neg2;
  logic [RW-1:0]      rhs2;
  logic [MAG_WIDTH-1:0] volt2;

  always_comb begin
    fscaled = (FB+IDXW)'(ang1[FB-1:0]) * (FB+IDXW)'(SINE_TABLE_DEPTH);
    idx     = IDXW'(fscaled >> FB);
    addr    = ang1[FB] ? (IDXW'(SINE_TABLE_DEPTH) - idx) : idx;
  end

  always_ff @(posedge clk) begin
    rom2  <= SINE_ROM[addr];
    neg2  <= ang1[ANGLE_WIDTH-1];
    rhs2  <= RW'(reach) * RW'(cur1);
    volt2 <= volt1;
  end

  // multiply stage
  logic [PW-1:0]        mul_a;
  logic [PW-1:0]        prod3;
  logic [RW-1:0]        rhs3;
  logic [MAG_WIDTH-1:0] volt3;
  logic                 neg3;
  logic                 pos3;

  always_comb begin
    if (char_mode == drp_pkg::MODE_MHO) mul_a = PW'(rhs2);
    else mul_a = PW'(volt2) << 8;
  end

  always_ff @(posedge clk) begin
    prod3 <= mul_a * PW'(rom2);
    rhs3  <= rhs2;
    volt3 <= volt2;
    neg3  <= neg2 && (rom2 != '0);
    pos3  <= !neg2 && (rom2 != '0);
  end

  // compare
  always_comb begin
    unique case (char_mode)
      drp_pkg::MODE_REACTANCE: begin
        if (neg3) pick = (volt3 != '0) || (reach != '0);
        else pick = prod3 < (PW'(rhs3) << 15);
      end
      drp_pkg::MODE_MHO: begin
        pick = pos3 && ((PW'(volt3) << 23) < prod3);
      end
      default: begin
        pick = (RW'(volt3) << 8) < rhs3;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/drp_merge.sv
`default_nettype none
module drp_merge (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire drp_pkg::merge_ctl_t  ctl,
  input  wire logic [2:0]           picks,
  input  wire logic                 m_tready,
  output logic                      m_tvalid,
  output logic [7:0]                m_tdata,
  output logic                      free
);

  logic [2:0] phase_pick;
  logic       any;
  logic       chg;

  assign free = !m_tvalid || m_tready;
  assign any  = |picks;
  assign chg  = picks != phase_pick;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_pick <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (ctl.load) begin
        phase_pick <= picks;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      m_tdata <= {3'b000, chg, any, picks};
    end
  end

endmodule
`default_nettype wire

FILE: sv/distance_relay_pickup.sv
// channel   dir  fields
// s_*       in   tdata: ia_mag ib_mag ic_mag va_mag vb_mag vc_mag ia_ang .. vc_ang
// m_*       out  tdata: pick_a pick_b pick_c pick_any changed
// cfg_*     in   0 char_mode, 1 reach, 2 torque_angle
//
// one request at a time, through load, table read, multiply, compare and merge
// each phase has its own lane with one sine table and three multipliers
// the result register frees the input while a result waits downstream
// a stalled output holds the lane load stage in the done state until the result register frees
// synchronous reset clears control and stored pickups and sets configuration to its defaults
`default_nettype none
module distance_relay_pickup #(
  parameter int MAG_WIDTH        = 16,
  parameter int ANGLE_WIDTH      = 16,
  parameter int SINE_TABLE_DEPTH = 1024,
  localparam int IN_BITS = 6 * MAG_WIDTH + 6 * ANGLE_WIDTH,
  localparam int IN_W    = ((IN_BITS + 7) / 8) * 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  // ia_mag, ib_mag, ic_mag, va_mag, vb_mag, vc_mag, ia_ang, ib_ang, ic_ang,
  // va_ang, vb_ang, vc_ang, zero fill
  input  wire logic [IN_W-1:0] s_tdata,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  // pick_a, pick_b, pick_c, pick_any, changed, zero fill
  output logic [7:0]           m_tdata,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [15:0]     cfg_data
);

  logic [1:0]  char_mode;
  logic [15:0] reach;
  logic [15:0] torque_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_mode    <= drp_pkg::MODE_IMPEDANCE;
      reach        <= '0;
      torque_angle <= drp_pkg::TORQUE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        drp_pkg::REG_CHAR_MODE:    char_mode    <= cfg_data[1:0];
        drp_pkg::REG_REACH:        reach        <= cfg_data;
        drp_pkg::REG_TORQUE_ANGLE: torque_angle <= cfg_data;
        default: ;
      endcase
    end
  end

  drp_pkg::state_t     state;
  drp_pkg::state_t     state_next;
  drp_pkg::lane_ctl_t  lane_ctl;
  drp_pkg::merge_ctl_t merge_ctl;
  logic                merge_free;

  always_ff @(posedge clk) begin
    if (rst) state <= drp_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      drp_pkg::ST_IDLE: if (s_tvalid) state_next = drp_pkg::ST_READ;
      drp_pkg::ST_READ: state_next = drp_pkg::ST_MUL;
      drp_pkg::ST_MUL:  state_next = drp_pkg::ST_DONE;
      drp_pkg::ST_DONE: if (merge_free) state_next = drp_pkg::ST_IDLE;
      default:          state_next = drp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready       = state == drp_pkg::ST_IDLE;
    lane_ctl.load  = s_tready && s_tvalid;
    merge_ctl.load = (state == drp_pkg::ST_DONE) && merge_free;
  end

  logic [2:0] picks;

  for (genvar p = 0; p < 3; p++) begin : g_lane
    drp_lane #(
      .MAG_WIDTH       (MAG_WIDTH),
      .ANGLE_WIDTH     (ANGLE_WIDTH),
      .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_lane (
      .clk         (clk),
      .ctl         (lane_ctl),
      .char_mode   (char_mode),
      .reach       (reach),
      .torque_angle(torque_angle),
      .cur         (s_tdata[p*MAG_WIDTH +: MAG_WIDTH]),
      .volt        (s_tdata[(3+p)*MAG_WIDTH +: MAG_WIDTH]),
      .iang        (s_tdata[6*MAG_WIDTH + p*ANGLE_WIDTH +: ANGLE_WIDTH]),
      .vang        (s_tdata[6*MAG_WIDTH + (3+p)*ANGLE_WIDTH +: ANGLE_WIDTH]),
      .pick        (picks[p])
    );
  end

  drp_merge u_merge (
    .clk     (clk),
    .rst     (rst),
    .ctl     (merge_ctl),
    .picks   (picks),
    .m_tready(m_tready),
    .m_tvalid(m_tvalid),
    .m_tdata (m_tdata),
    .free    (merge_free)
  );

endmodule
`default_nettype wire

FILE: sv/drp_checker.sv
`default_nettype none
module drp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result shown after reset");

  a_any: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[3] == (|m_tdata[2:0])) && (m_tdata[7:5] == 3'b000))
    else $error("pick_any or fill bits wrong");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind distance_relay_pickup drp_checker u_drp_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
`default_nettype wire
